/* rtl/core/ring_queue_with_reserve_stack_assert.svh */
// ----------------------------------------------------------------------------
// Ring queue with reserve stack: assertion macros
// Shared macros for the concurrent checks of the block, clocked on clk_i.
// ----------------------------------------------------------------------------
`ifndef RING_QUEUE_WITH_RESERVE_STACK_ASSERT_SVH
`define RING_QUEUE_WITH_RESERVE_STACK_ASSERT_SVH

// Overlapping implication: the consequent holds in the same cycle.
`define RQRS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("rqrs check failed");

// Non-overlapping implication: the consequent holds in the next cycle.
`define RQRS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("rqrs check failed");

`endif

/* rtl/core/rqrs_pkg.sv */
// ----------------------------------------------------------------------------
// Ring queue with reserve stack package
// Field widths, operation and status codes, and the structs between modules.
// ----------------------------------------------------------------------------
package rqrs_pkg;

  localparam int QUEUE_DEPTH_DEF = 8;
  localparam int STACK_DEPTH_DEF = 4;

  localparam int OP_W     = 3;
  localparam int TAG_W    = 8;
  localparam int NUM_W    = 16;
  localparam int ITEM_W   = TAG_W + NUM_W;
  localparam int STATUS_W = 3;
  localparam int QFILL_W  = 4;
  localparam int SFILL_W  = 3;

  // Operation codes of a request.
  typedef enum logic [OP_W-1:0] {
    OP_ENQUEUE = 3'd0,
    OP_DEQUEUE = 3'd1,
    OP_RESERVE = 3'd2,
    OP_POP     = 3'd3,
    OP_PEEK    = 3'd4
  } op_e;

  // Status codes of a result.
  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 3'd0,
    ST_QFULL  = 3'd1,
    ST_QEMPTY = 3'd2,
    ST_SFULL  = 3'd3,
    ST_SEMPTY = 3'd4
  } status_e;

  // Write strobes from the controller to the storage.
  typedef struct packed {
    logic q_we;
    logic s_we;
  } mem_ctl_t;

  // Result qualifiers for the cycle in which a result is shown.
  typedef struct packed {
    logic    done;
    logic    valid;
    logic    from_stack;
    status_e status;
  } res_t;

endpackage

/* rtl/core/rqrs_store.sv */
// ----------------------------------------------------------------------------
// Ring queue with reserve stack storage
// Queue and stack memories with registered reads, and the result item mux.
// ----------------------------------------------------------------------------
module rqrs_store #(
  parameter int QUEUE_DEPTH = rqrs_pkg::QUEUE_DEPTH_DEF,
  parameter int STACK_DEPTH = rqrs_pkg::STACK_DEPTH_DEF,
  parameter int QAW = $clog2(QUEUE_DEPTH),
  parameter int SAW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1
) (
  input  logic                         clk_i,
  input  rqrs_pkg::mem_ctl_t           ctl_i,
  input  rqrs_pkg::res_t               res_i,
  input  logic [QAW-1:0]               q_waddr_i,
  input  logic [QAW-1:0]               q_raddr_i,
  input  logic [rqrs_pkg::ITEM_W-1:0]  q_wdata_i,
  input  logic [SAW-1:0]               s_addr_i,
  output logic [rqrs_pkg::ITEM_W-1:0]  item_o
);
  import rqrs_pkg::*;

  logic [ITEM_W-1:0] queue_mem [QUEUE_DEPTH];
  logic [ITEM_W-1:0] stack_mem [STACK_DEPTH];
  logic [ITEM_W-1:0] q_rdata_q;
  logic [ITEM_W-1:0] s_rdata_q;

  // Queue memory: one write port at the tail, one registered read at the head.
  always_ff @(posedge clk_i) begin
    if (ctl_i.q_we) begin
      queue_mem[q_waddr_i] <= q_wdata_i;
    end
    q_rdata_q <= queue_mem[q_raddr_i];
  end

  // Stack memory: a reserve writes back the queue head read in the cycle before.
  always_ff @(posedge clk_i) begin
    if (ctl_i.s_we) begin
      stack_mem[s_addr_i] <= q_rdata_q;
    end
    s_rdata_q <= stack_mem[s_addr_i];
  end

  // The item is zero whenever the result carries none.
  always_comb begin
    if (!res_i.valid) begin
      item_o = '0;
    end else if (res_i.from_stack) begin
      item_o = s_rdata_q;
    end else begin
      item_o = q_rdata_q;
    end
  end

endmodule

/* rtl/core/rqrs_ctrl.sv */
// ----------------------------------------------------------------------------
// Ring queue with reserve stack controller
// Decodes requests, keeps pointers and fill counts, and drives the memories.
// ----------------------------------------------------------------------------
module rqrs_ctrl #(
  parameter int QUEUE_DEPTH = rqrs_pkg::QUEUE_DEPTH_DEF,
  parameter int STACK_DEPTH = rqrs_pkg::STACK_DEPTH_DEF,
  parameter int QAW = $clog2(QUEUE_DEPTH),
  parameter int SAW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1,
  parameter int QCW = $clog2(QUEUE_DEPTH + 1),
  parameter int SCW = $clog2(STACK_DEPTH + 1)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [rqrs_pkg::OP_W-1:0]  operation_i,
  output logic                       busy_o,
  output rqrs_pkg::mem_ctl_t         ctl_o,
  output rqrs_pkg::res_t             res_o,
  output logic [QAW-1:0]             q_waddr_o,
  output logic [QAW-1:0]             q_raddr_o,
  output logic [SAW-1:0]             s_addr_o,
  output logic [QCW-1:0]             q_count_o,
  output logic [SCW-1:0]             s_count_o
);
  import rqrs_pkg::*;

  logic [QAW-1:0] q_head_q, q_head_d, q_head_inc;
  logic [QAW-1:0] q_tail_q, q_tail_d, q_tail_inc;
  logic [QCW-1:0] q_count_q, q_count_d;
  logic [SCW-1:0] s_count_q, s_count_d;
  logic           wb_q, wb_d;
  res_t           res_q, res_d;
  logic           accept;
  logic           enq_ok;
  logic           q_empty, q_full, s_empty, s_full;

  assign accept  = start_i && !wb_q;
  assign q_empty = (q_count_q == '0);
  assign q_full  = (q_count_q == QCW'(QUEUE_DEPTH));
  assign s_empty = (s_count_q == '0);
  assign s_full  = (s_count_q == SCW'(STACK_DEPTH));

  // Ring pointers wrap at the queue depth.
  assign q_head_inc = (q_head_q == QAW'(QUEUE_DEPTH - 1)) ? '0 : q_head_q + 1'b1;
  assign q_tail_inc = (q_tail_q == QAW'(QUEUE_DEPTH - 1)) ? '0 : q_tail_q + 1'b1;

  // Next state for the request on the inputs; taken only when it is accepted.
  always_comb begin
    q_head_d  = q_head_q;
    q_tail_d  = q_tail_q;
    q_count_d = q_count_q;
    s_count_d = s_count_q;
    wb_d      = 1'b0;
    enq_ok    = 1'b0;
    res_d     = '{done: 1'b1, valid: 1'b0, from_stack: 1'b0, status: ST_OK};
    case (operation_i)
      OP_ENQUEUE: begin
        if (q_full) begin
          res_d.status = ST_QFULL;
        end else begin
          enq_ok    = 1'b1;
          q_tail_d  = q_tail_inc;
          q_count_d = q_count_q + 1'b1;
        end
      end
      OP_DEQUEUE: begin
        if (q_empty) begin
          res_d.status = ST_QEMPTY;
        end else begin
          res_d.valid = 1'b1;
          q_head_d    = q_head_inc;
          q_count_d   = q_count_q - 1'b1;
        end
      end
      OP_RESERVE: begin
        if (q_empty) begin
          res_d.status = ST_QEMPTY;
        end else if (s_full) begin
          res_d.status = ST_SFULL;
        end else begin
          res_d.valid = 1'b1;
          q_head_d    = q_head_inc;
          q_count_d   = q_count_q - 1'b1;
          s_count_d   = s_count_q + 1'b1;
          wb_d        = 1'b1;
        end
      end
      OP_POP: begin
        if (s_empty) begin
          res_d.status = ST_SEMPTY;
        end else begin
          res_d.valid      = 1'b1;
          res_d.from_stack = 1'b1;
          s_count_d        = s_count_q - 1'b1;
        end
      end
      OP_PEEK: begin
        if (s_empty) begin
          res_d.status = ST_SEMPTY;
        end else begin
          res_d.valid      = 1'b1;
          res_d.from_stack = 1'b1;
        end
      end
      default: begin
        // Unknown operations leave everything unchanged and report ok.
      end
    endcase
  end

  // Pointers, counts and the result qualifiers; the qualifiers clear when nothing is accepted.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q_head_q  <= '0;
      q_tail_q  <= '0;
      q_count_q <= '0;
      s_count_q <= '0;
      wb_q      <= 1'b0;
      res_q     <= '{done: 1'b0, valid: 1'b0, from_stack: 1'b0, status: ST_OK};
    end else begin
      wb_q <= accept && wb_d;
      if (accept) begin
        q_head_q  <= q_head_d;
        q_tail_q  <= q_tail_d;
        q_count_q <= q_count_d;
        s_count_q <= s_count_d;
        res_q     <= res_d;
      end else begin
        res_q     <= '{done: 1'b0, valid: 1'b0, from_stack: 1'b0, status: ST_OK};
      end
    end
  end

  // The stack top serves reads before a request and the reserve write-back after.
  assign s_addr_o   = SAW'(s_count_q - 1'b1);
  assign q_waddr_o  = q_tail_q;
  assign q_raddr_o  = q_head_q;
  assign ctl_o.q_we = accept && enq_ok;
  assign ctl_o.s_we = wb_q;
  assign busy_o     = wb_q;
  assign res_o      = res_q;
  assign q_count_o  = q_count_q;
  assign s_count_o  = s_count_q;

endmodule

/* rtl/core/ring_queue_with_reserve_stack.sv */
// ----------------------------------------------------------------------------
// Ring queue with reserve stack
// Circular queue of tagged items with a small reserve stack fed from its head.
// ----------------------------------------------------------------------------
// A request (operation_i, item_tag_i, item_number_i) is taken at a rising edge
// with start_i high and busy_o low. Exactly one result follows in the next
// cycle: done_o is high for that one cycle, together with out_tag_o,
// out_number_o, out_valid_o, status_o and the fill counts after the request.
// Enqueue, dequeue, pop, peek and failed requests can be issued back to back.
// After a successful reserve, the queue head comes out of the queue memory's
// registered read port, and busy_o stays high for the cycle in which it is
// written back into the stack memory, so no request is taken in that cycle.
// Reset clears both pointers and both counts; the memory contents are not
// cleared and no clearing pass runs, since entries are only read once written.
// The receiver cannot stall: each result is valid only during its done_o cycle.
// ----------------------------------------------------------------------------
module ring_queue_with_reserve_stack #(
  parameter int QUEUE_DEPTH = rqrs_pkg::QUEUE_DEPTH_DEF,
  parameter int STACK_DEPTH = rqrs_pkg::STACK_DEPTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  output logic                           busy_o,
  input  logic [rqrs_pkg::OP_W-1:0]      operation_i,
  input  logic [rqrs_pkg::TAG_W-1:0]     item_tag_i,
  input  logic [rqrs_pkg::NUM_W-1:0]     item_number_i,
  output logic                           done_o,
  output logic [rqrs_pkg::TAG_W-1:0]     out_tag_o,
  output logic [rqrs_pkg::NUM_W-1:0]     out_number_o,
  output logic                           out_valid_o,
  output logic [rqrs_pkg::STATUS_W-1:0]  status_o,
  output logic [rqrs_pkg::QFILL_W-1:0]   queue_fill_o,
  output logic [rqrs_pkg::SFILL_W-1:0]   stack_fill_o
);
  import rqrs_pkg::*;

  localparam int QAW = $clog2(QUEUE_DEPTH);
  localparam int SAW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int QCW = $clog2(QUEUE_DEPTH + 1);
  localparam int SCW = $clog2(STACK_DEPTH + 1);

  mem_ctl_t          ctl;
  res_t              res;
  logic [QAW-1:0]    q_waddr, q_raddr;
  logic [SAW-1:0]    s_addr;
  logic [QCW-1:0]    q_count;
  logic [SCW-1:0]    s_count;
  logic [ITEM_W-1:0] item;

  // Request decode, pointers and counts.
  rqrs_ctrl #(
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .STACK_DEPTH(STACK_DEPTH),
    .QAW(QAW),
    .SAW(SAW),
    .QCW(QCW),
    .SCW(SCW)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .operation_i(operation_i),
    .busy_o     (busy_o),
    .ctl_o      (ctl),
    .res_o      (res),
    .q_waddr_o  (q_waddr),
    .q_raddr_o  (q_raddr),
    .s_addr_o   (s_addr),
    .q_count_o  (q_count),
    .s_count_o  (s_count)
  );

  // Queue and stack memories.
  rqrs_store #(
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .STACK_DEPTH(STACK_DEPTH),
    .QAW(QAW),
    .SAW(SAW)
  ) u_store (
    .clk_i    (clk_i),
    .ctl_i    (ctl),
    .res_i    (res),
    .q_waddr_i(q_waddr),
    .q_raddr_i(q_raddr),
    .q_wdata_i({item_tag_i, item_number_i}),
    .s_addr_i (s_addr),
    .item_o   (item)
  );

  // Result ports.
  assign done_o       = res.done;
  assign out_valid_o  = res.valid;
  assign status_o     = res.status;
  assign out_tag_o    = item[ITEM_W-1:NUM_W];
  assign out_number_o = item[NUM_W-1:0];
  assign queue_fill_o = QFILL_W'(q_count);
  assign stack_fill_o = SFILL_W'(s_count);

  // Checks.
`include "ring_queue_with_reserve_stack_assert.svh"
  `RQRS_ASSERT_NEXT(a_result_follows, start_i && !busy_o, done_o)
  `RQRS_ASSERT_NOW(a_item_means_ok, out_valid_o, done_o && (status_o == ST_OK))
  `RQRS_ASSERT_NOW(a_writeback_in_result, busy_o, done_o && out_valid_o)

endmodule
